FILE: sv/obb_pkg.sv
package obb_pkg;

	// Field widths
	localparam int TIME_W   = 32;
	localparam int PRICE_W  = 40;
	localparam int AMOUNT_W = 40;
	localparam int VOL_W    = 48;
	localparam int SUM_W    = 64;
	localparam int CNT_W    = 24;
	localparam int BS_W     = 17;
	localparam int NB_W     = 7;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS     = 2'd2;

	localparam logic [BS_W-1:0] BIN_SIZE_RESET = 17'd60;
	localparam logic [NB_W-1:0] NUM_BINS_RESET = 7'd64;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [VOL_W-1:0] VOL_MAX   = {VOL_W{1'b1}};

	// Input item kinds
	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [TIME_W-1:0]   trade_time;
		logic [PRICE_W-1:0]  trade_price;
		logic [AMOUNT_W-1:0] trade_amount;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]  bin_time;
		logic [PRICE_W-1:0] open_price;
		logic [PRICE_W-1:0] close_price;
		logic [PRICE_W-1:0] high_price;
		logic [PRICE_W-1:0] low_price;
		logic [PRICE_W-1:0] average_price;
		logic [VOL_W-1:0]   volume;
		logic               had_trades;
		logic               last_of_run;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic add_trade;
		logic start_div;
		logic emit;
		logic set_done;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic done;
		logic kind;
		logic below_ws;
		logic below_lo;
		logic in_bin;
		logic beyond;
		logic flush_more;
		logic has_trades;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

FILE: sv/obb_in_if.sv
interface obb_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [obb_pkg::TIME_W-1:0]   trade_time;
	logic [obb_pkg::PRICE_W-1:0]  trade_price;
	logic [obb_pkg::AMOUNT_W-1:0] trade_amount;

	modport source (
		output valid, kind, trade_time, trade_price, trade_amount,
		input  ready
	);

	modport sink (
		input  valid, kind, trade_time, trade_price, trade_amount,
		output ready
	);
endinterface

FILE: sv/obb_out_if.sv
interface obb_out_if;
	logic                        valid;
	logic                        ready;
	logic [obb_pkg::TIME_W-1:0]  bin_time;
	logic [obb_pkg::PRICE_W-1:0] open_price;
	logic [obb_pkg::PRICE_W-1:0] close_price;
	logic [obb_pkg::PRICE_W-1:0] high_price;
	logic [obb_pkg::PRICE_W-1:0] low_price;
	logic [obb_pkg::PRICE_W-1:0] average_price;
	logic [obb_pkg::VOL_W-1:0]   volume;
	logic                        had_trades;
	logic                        last_of_run;

	modport source (
		output valid, bin_time, open_price, close_price, high_price, low_price,
		       average_price, volume, had_trades, last_of_run,
		input  ready
	);

	modport sink (
		input  valid, bin_time, open_price, close_price, high_price, low_price,
		       average_price, volume, had_trades, last_of_run,
		output ready
	);
endinterface

FILE: sv/obb_div.sv
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// PRICE_W bits, so the top of the dividend seeds the remainder directly.
module obb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [obb_pkg::SUM_W-1:0]   dividend,
	input  logic [obb_pkg::CNT_W-1:0]   divisor,
	output logic                        busy,
	output logic [obb_pkg::PRICE_W-1:0] quotient
);
	localparam int QW    = obb_pkg::PRICE_W;
	localparam int RW    = obb_pkg::CNT_W;
	localparam int CTR_W = $clog2(QW + 1);

	logic [RW-1:0]    rem_q;
	logic [QW-1:0]    acc_q;
	logic [CTR_W-1:0] cnt_q;
	logic             busy_q;
	logic [RW+1:0]    trial;
	logic             neg;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {1'b0, rem_q, acc_q[QW-1]} - {2'b00, divisor};
	assign neg   = trial[RW+1];

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CTR_W'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CTR_W'(1);
			if (cnt_q == CTR_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[obb_pkg::SUM_W-1:QW];
			acc_q <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= neg ? {rem_q[RW-2:0], acc_q[QW-1]} : trial[RW-1:0];
			acc_q <= {acc_q[QW-2:0], ~neg};
		end
	end

	assign busy     = busy_q;
	assign quotient = acc_q;
endmodule

FILE: sv/obb_dp.sv
// Datapath: configuration, open-bin accumulators, bin window tracking,
// mean divider and the output register.
module obb_dp #(
	parameter int NUM_BINS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [obb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [obb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  obb_pkg::in_item_t                   in_item,
	input  obb_pkg::cmd_t                       cmd,
	output obb_pkg::status_t                    st,
	input  logic                                out_ready,
	output logic                                out_valid,
	output obb_pkg::out_item_t                  out_item
);
	localparam int IDX_W = $clog2(NUM_BINS + 1);
	localparam int LO_W  = IDX_W + obb_pkg::BS_W;
	localparam int HI_W  = LO_W + 2;
	localparam int TW    = obb_pkg::TIME_W;
	localparam int PW    = obb_pkg::PRICE_W;
	localparam int VW    = obb_pkg::VOL_W;
	localparam int CW    = obb_pkg::CNT_W;

	// Configuration registers
	logic [obb_pkg::BS_W-1:0] cfg_bs_q;
	logic [TW-1:0]            cfg_ws_q;
	logic [obb_pkg::NB_W-1:0] cfg_nb_q;
	logic                     cfg_hit;

	// Latched request
	logic                         item_kind_q;
	logic [TW-1:0]                item_time_q;
	logic [PW-1:0]                item_price_q;
	logic [obb_pkg::AMOUNT_W-1:0] item_amount_q;
	logic [TW:0]                  diff_q;

	// Window state
	logic [IDX_W-1:0]          idx_q;
	logic [LO_W-1:0]           lo_q;
	logic [LO_W-1:0]           lim_q;
	logic [PW-1:0]             open_q;
	logic [PW-1:0]             high_q;
	logic [PW-1:0]             low_q;
	logic [PW-1:0]             close_q;
	logic [TW-1:0]             newest_q;
	logic [obb_pkg::SUM_W-1:0] sum_q;
	logic [CW-1:0]             count_q;
	logic [VW-1:0]             vol_q;
	logic [PW-1:0]             prev_avg_q;
	logic                      have_prev_q;
	logic                      done_q;

	// Output register
	logic               out_valid_q;
	obb_pkg::out_item_t out_q;

	logic [obb_pkg::BS_W-1:0] bse;
	logic [IDX_W-1:0]         nbe;
	logic [TW-1:0]            d;
	logic [HI_W-1:0]          hi1;
	logic [HI_W-1:0]          hi2;
	logic [IDX_W:0]           idx_inc;
	logic                     first;
	logic [VW:0]              vol_add;
	logic [PW-1:0]            fill;
	logic [PW-1:0]            quotient;
	logic                     div_busy;
	logic                     last;
	logic                     out_free;
	obb_pkg::out_item_t       emit_item;

	// Decode the register index
	always_comb begin
		unique case (cfg_index) inside
			obb_pkg::CFG_BIN_SIZE, obb_pkg::CFG_WINDOW_START,
			obb_pkg::CFG_NUM_BINS: cfg_hit = cfg_we;
			default:               cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bs_q <= obb_pkg::BIN_SIZE_RESET;
			cfg_ws_q <= '0;
			cfg_nb_q <= obb_pkg::NUM_BINS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				obb_pkg::CFG_BIN_SIZE:     cfg_bs_q <= cfg_data[obb_pkg::BS_W-1:0];
				obb_pkg::CFG_WINDOW_START: cfg_ws_q <= cfg_data[TW-1:0];
				obb_pkg::CFG_NUM_BINS:     cfg_nb_q <= cfg_data[obb_pkg::NB_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective bin size and bin count
	assign bse = (cfg_bs_q == '0) ? obb_pkg::BS_W'(1) : cfg_bs_q;
	always_comb begin
		if (cfg_nb_q == '0) begin
			nbe = IDX_W'(1);
		end else if (cfg_nb_q > obb_pkg::NB_W'(NUM_BINS)) begin
			nbe = IDX_W'(NUM_BINS);
		end else begin
			nbe = cfg_nb_q[IDX_W-1:0];
		end
	end

	// Window end offset, refreshed every cycle from the registers
	always_ff @(posedge clk) begin
		lim_q <= LO_W'(nbe) * LO_W'(bse);
	end

	// Capture the request and its offset into the window
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_kind_q   <= in_item.kind;
			item_time_q   <= in_item.trade_time;
			item_price_q  <= in_item.trade_price;
			item_amount_q <= in_item.trade_amount;
			diff_q        <= {1'b0, in_item.trade_time} - {1'b0, cfg_ws_q};
		end
	end

	assign d       = diff_q[TW-1:0];
	assign hi1     = HI_W'(lo_q) + HI_W'(bse);
	assign hi2     = hi1 + HI_W'(bse);
	assign idx_inc = {1'b0, idx_q} + (IDX_W + 1)'(1);
	assign first   = (count_q == '0);
	assign vol_add = {1'b0, vol_q} + (VW + 1)'(item_amount_q);
	assign fill    = have_prev_q ? prev_avg_q : '0;

	// Last bin of this run: the next check either adds the trade or ends the flush
	assign last = (item_kind_q == obb_pkg::KIND_FLUSH) ? (idx_inc >= {1'b0, nbe})
	                                                   : (d <= TW'(hi2));

	// Mean of the open bin
	obb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Assemble the closing bin
	always_comb begin
		if (!first) begin
			emit_item.bin_time      = newest_q;
			emit_item.open_price    = open_q;
			emit_item.close_price   = close_q;
			emit_item.high_price    = high_q;
			emit_item.low_price     = low_q;
			emit_item.average_price = quotient;
			emit_item.volume        = vol_q;
			emit_item.had_trades    = 1'b1;
		end else begin
			emit_item.bin_time      = cfg_ws_q + TW'(lo_q);
			emit_item.open_price    = fill;
			emit_item.close_price   = fill;
			emit_item.high_price    = fill;
			emit_item.low_price     = fill;
			emit_item.average_price = fill;
			emit_item.volume        = '0;
			emit_item.had_trades    = 1'b0;
		end
		emit_item.last_of_run = last;
	end

	// Window state: restart on configuration, mark the window done, close bins, add trades
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			lo_q        <= '0;
			open_q      <= '0;
			high_q      <= '0;
			low_q       <= '0;
			close_q     <= '0;
			newest_q    <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			vol_q       <= '0;
			prev_avg_q  <= '0;
			have_prev_q <= 1'b0;
			done_q      <= 1'b0;
		end else if (cfg_hit) begin
			idx_q       <= '0;
			lo_q        <= '0;
			open_q      <= '0;
			high_q      <= '0;
			low_q       <= '0;
			close_q     <= '0;
			newest_q    <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			vol_q       <= '0;
			prev_avg_q  <= '0;
			have_prev_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			if (cmd.emit) begin
				prev_avg_q  <= emit_item.average_price;
				have_prev_q <= 1'b1;
				idx_q       <= idx_q + IDX_W'(1);
				lo_q        <= lo_q + LO_W'(bse);
				open_q      <= '0;
				high_q      <= '0;
				low_q       <= '0;
				close_q     <= '0;
				newest_q    <= '0;
				sum_q       <= '0;
				count_q     <= '0;
				vol_q       <= '0;
			end else if (cmd.add_trade) begin
				if (first) begin
					open_q <= item_price_q;
				end
				if (first || item_price_q > high_q) begin
					high_q <= item_price_q;
				end
				if (first || item_price_q < low_q) begin
					low_q <= item_price_q;
				end
				close_q  <= item_price_q;
				newest_q <= item_time_q;
				if (count_q < obb_pkg::COUNT_MAX) begin
					count_q <= count_q + CW'(1);
					sum_q   <= sum_q + obb_pkg::SUM_W'(item_price_q);
				end
				vol_q <= vol_add[VW] ? obb_pkg::VOL_MAX : vol_add[VW-1:0];
			end
		end
	end

	// Hold a result until the sink takes it
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Status toward the controller
	assign st.done       = done_q;
	assign st.kind       = item_kind_q;
	assign st.below_ws   = diff_q[TW];
	assign st.below_lo   = d < TW'(lo_q);
	assign st.in_bin     = d <= TW'(hi1);
	assign st.beyond     = d > TW'(lim_q);
	assign st.flush_more = idx_q < nbe;
	assign st.has_trades = !first;
	assign st.div_busy   = div_busy;
	assign st.out_free   = out_free;
endmodule

FILE: sv/obb_ctrl.sv
// Controller: classify each request, then close bins one by one.
module obb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  obb_pkg::status_t st,
	output obb_pkg::cmd_t    cmd
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EVAL  = 5'b00010,
		S_CLOSE = 5'b00100,
		S_DIV   = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.latch     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				if (st.done) begin
					state_d = S_IDLE;
				end else if (st.kind == obb_pkg::KIND_FLUSH) begin
					if (st.flush_more) begin
						state_d = S_CLOSE;
					end else begin
						cmd.set_done = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (st.below_ws || st.below_lo) begin
					state_d = S_IDLE;
				end else if (st.in_bin) begin
					cmd.add_trade = 1'b1;
					state_d       = S_IDLE;
				end else if (st.beyond) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				if (st.has_trades) begin
					cmd.start_div = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_DIV: begin
				if (!st.div_busy) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_EVAL;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> !st.div_busy)
		else $error("divider started while busy");

	a_emit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (st.out_free && !st.div_busy))
		else $error("bin closed without free output or with mean pending");

	a_add_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_trade |-> (!st.done && st.kind == obb_pkg::KIND_TRADE && !st.below_lo))
		else $error("trade added to a finished window or older bin");

	a_done_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_done |-> (st.kind == obb_pkg::KIND_FLUSH && !st.flush_more))
		else $error("window closed with bins left");
endmodule

FILE: sv/trade_ohlc_bar_binner_core.sv
// OHLC bar binner. Trades (oldest first) fall into bins of bin_size seconds
// starting at window_start; each closed bin comes out as one result with
// open, close, high, low, truncated mean and saturating volume, empty bins
// carrying the previous mean forward. A flush request closes the rest of the
// window. One request is handled at a time. A trade inside the open bin, or a
// dropped one, is accepted and then classified. An empty bin closes without
// the divider; one that held trades waits on the one-bit-per-cycle divider
// that forms the 40-bit mean. A full output register stalls closing.
// Any write to a listed register restarts the window.
module trade_ohlc_bar_binner_core #(
	parameter int NUM_BINS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [obb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [obb_pkg::CFG_DATA_W-1:0]    cfg_data,
	obb_in_if.sink                            in_ch,
	obb_out_if.source                         out_ch
);
	obb_pkg::cmd_t      cmd;
	obb_pkg::status_t   st;
	obb_pkg::in_item_t  in_item;
	obb_pkg::out_item_t out_item;

	// Pack the request
	assign in_item.kind         = in_ch.kind;
	assign in_item.trade_time   = in_ch.trade_time;
	assign in_item.trade_price  = in_ch.trade_price;
	assign in_item.trade_amount = in_ch.trade_amount;

	obb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	obb_dp #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.st        (st),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_item  (out_item)
	);

	// Unpack the result
	assign out_ch.bin_time      = out_item.bin_time;
	assign out_ch.open_price    = out_item.open_price;
	assign out_ch.close_price   = out_item.close_price;
	assign out_ch.high_price    = out_item.high_price;
	assign out_ch.low_price     = out_item.low_price;
	assign out_ch.average_price = out_item.average_price;
	assign out_ch.volume        = out_item.volume;
	assign out_ch.had_trades    = out_item.had_trades;
	assign out_ch.last_of_run   = out_item.last_of_run;
endmodule
